// File: design/sobel_pkg.sv
// ============================================================================
// sobel_pkg
// Shared widths, constants, register indexes and types of the Sobel edge core.
// ============================================================================
`default_nettype none

package sobel_pkg;

    // Field and register widths
    localparam int PIXEL_W        = 32;
    localparam int LUM_W          = 8;
    localparam int FRAME_WIDTH_W  = 12;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int THRESHOLD_W    = 8;
    localparam int OUT_COL_W      = 11;
    localparam int OUT_ROW_W      = 12;
    localparam int ROW_CNT_W      = 12;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 56;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

    // Reset values
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST    = 12'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST   = 13'd480;
    localparam logic [THRESHOLD_W-1:0]    EDGE_THRESHOLD_RST = 8'd30;

    // Geometry limits
    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam logic [FRAME_HEIGHT_W-1:0] ROW_LIMIT = 13'd4096;

    // BT.601 luma weights, sum scaled by 1000
    localparam int WSUM_W = 18;
    localparam logic [8:0] LUMA_R = 9'd299;
    localparam logic [9:0] LUMA_G = 10'd587;
    localparam logic [6:0] LUMA_B = 7'd114;

    // Divide by 1000 as multiply by ceil(2^28/1000), exact for sums below 2^18
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

    // Output pixel constants
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [10:0] MAG_MAX = 11'd255;

    typedef logic [LUM_W-1:0] lum_t;

endpackage : sobel_pkg

`default_nettype wire

// File: design/sobel_ram.sv
// ============================================================================
// sobel_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module sobel_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : sobel_ram

`default_nettype wire

// File: design/sobel_luma.sv
// ============================================================================
// sobel_luma
// BT.601 luminance: registered weighted sum, then divide by 1000 by reciprocal.
// ============================================================================
`default_nettype none

module sobel_luma (
    input  wire logic                            aclk,
    input  wire logic                            en,
    input  wire logic [sobel_pkg::PIXEL_W-1:0]   pixel_rgba,
    output sobel_pkg::lum_t                      lum
);

    import sobel_pkg::*;

    logic [WSUM_W-1:0]          wsum_reg;
    logic [WSUM_W-1:0]          wsum_next;
    logic [WSUM_W+RECIP_W-1:0]  prod;

    // Weighted sum of red, green and blue; transparent pixel gives zero
    always_comb begin
        if (pixel_rgba[31:24] == 8'd0) begin
            wsum_next = '0;
        end else begin
            wsum_next = WSUM_W'(pixel_rgba[7:0])   * WSUM_W'(LUMA_R)
                      + WSUM_W'(pixel_rgba[15:8])  * WSUM_W'(LUMA_G)
                      + WSUM_W'(pixel_rgba[23:16]) * WSUM_W'(LUMA_B);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wsum_reg <= wsum_next;
        end
    end

    // Quotient by 1000, always below 256
    assign prod = (WSUM_W+RECIP_W)'(wsum_reg) * (WSUM_W+RECIP_W)'(RECIP_1000);
    assign lum  = prod[RECIP_SHIFT+LUM_W-1:RECIP_SHIFT];

endmodule : sobel_luma

`default_nettype wire

// File: design/sobel_edge_threshold_core.sv
// ============================================================================
// sobel_edge_threshold_core
// Streaming 3x3 Sobel edge detector with threshold on BT.601 luminance.
// ============================================================================
//
//  Channel   Direction  Payload                                  Handshake
//  s_axis    in         tdata: pixel_rgba; tuser: frame_start    tvalid/tready
//  m_axis    out        tdata: edge_pixel, col, row; tlast: done tvalid/tready
//  cfg       in         cfg_addr, cfg_wr_data                    cfg_wr_en
//
//  One pixel per cycle unless m_axis stalls; the rate is set by the single
//  read and single write per cycle on each line buffer. The luma sum and
//  buffer read are registered at the pixel transfer; stage 2 captures the
//  divided luma and buffer data, then the output register the Sobel result.
//  Synchronous active-low reset restores the register defaults and clears
//  counters, window and valid bits; the line buffers are not cleared. A stall
//  on m_axis freezes the whole pipeline and drops s_axis_tready. Border pixels
//  are consumed without a result.
// ============================================================================
`default_nettype none

module sobel_edge_threshold_core #(
    parameter int MAX_WIDTH = sobel_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // pixel input
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [sobel_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [31:0] pixel_rgba
    input  wire logic                               s_axis_tuser,  // [0] frame_start
    // edge result output
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [sobel_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [31:0] edge_pixel,
                                                                   // [42:32] pixel_col,
                                                                   // [54:43] pixel_row,
                                                                   // [55] zero
    output logic                                    m_axis_tlast,  // frame_done
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [sobel_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [sobel_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    import sobel_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int MAXW_W  = $clog2(MAX_WIDTH + 1);
    localparam int EW_W    = (FRAME_WIDTH_W > MAXW_W) ? FRAME_WIDTH_W : MAXW_W;
    localparam int SUM_W   = LUM_W + 2;

    // Configuration registers
    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [THRESHOLD_W-1:0]    edge_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg    <= FRAME_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            edge_threshold_reg <= EDGE_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wr_data[FRAME_WIDTH_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wr_data[FRAME_HEIGHT_W-1:0];
                end
                REG_EDGE_THRESHOLD: begin
                    edge_threshold_reg <= cfg_wr_data[THRESHOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline advance: everything moves when the output register is free
    logic adv;
    logic in_xfer;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_xfer       = s_axis_tvalid && adv;

    // Effective frame size
    logic [EW_W-1:0]           ew;
    logic [FRAME_HEIGHT_W-1:0] eh;

    always_comb begin
        if (frame_width_reg == '0) begin
            ew = EW_W'(1);
        end else if (EW_W'(frame_width_reg) > EW_W'(MAX_WIDTH)) begin
            ew = EW_W'(MAX_WIDTH);
        end else begin
            ew = EW_W'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            eh = FRAME_HEIGHT_W'(1);
        end else if (frame_height_reg > ROW_LIMIT) begin
            eh = ROW_LIMIT;
        end else begin
            eh = frame_height_reg;
        end
    end

    // Position counters (position of the next pixel)
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [ROW_CNT_W-1:0] row_reg;
    logic [ROW_CNT_W-1:0] row_next;

    logic [EW_W-1:0]           col_start, col_cur, col_inc, col_m1;
    logic [FRAME_HEIGHT_W-1:0] row_start, row_fix, row_cur, row_inc, row_m1;
    logic                      emit_cur;
    logic                      done_cur;

    always_comb begin
        col_start = s_axis_tuser ? '0 : EW_W'(col_reg);
        row_start = s_axis_tuser ? '0 : FRAME_HEIGHT_W'(row_reg);

        // column past a lowered width wraps before use
        if (col_start >= ew) begin
            col_cur = '0;
            row_fix = row_start + FRAME_HEIGHT_W'(1);
        end else begin
            col_cur = col_start;
            row_fix = row_start;
        end
        row_cur = (row_fix >= eh) ? '0 : row_fix;

        // advance past this pixel
        col_inc = col_cur + EW_W'(1);
        row_inc = row_cur + FRAME_HEIGHT_W'(1);
        if (col_inc >= ew) begin
            col_next = '0;
            row_next = (row_inc >= eh) ? '0 : row_inc[ROW_CNT_W-1:0];
        end else begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_cur[ROW_CNT_W-1:0];
        end

        emit_cur = (col_cur >= EW_W'(2)) && (row_cur >= FRAME_HEIGHT_W'(2));
        done_cur = (col_cur == ew - EW_W'(1)) && (row_cur == eh - FRAME_HEIGHT_W'(1));
        col_m1   = col_cur - EW_W'(1);
        row_m1   = row_cur - FRAME_HEIGHT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_xfer) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Luminance unit: sum registered at transfer, quotient ready in stage 1
    lum_t lum1;

    sobel_luma u_luma (
        .aclk       (aclk),
        .en         (in_xfer),
        .pixel_rgba (s_axis_tdata[PIXEL_W-1:0]),
        .lum        (lum1)
    );

    // Line buffers
    lum_t             up_rd, mid_rd;
    logic             buf_wr_en;
    logic [COL_W-1:0] buf_wr_addr;
    lum_t             up_wr_data, mid_wr_data;

    sobel_ram #(
        .DATA_W (LUM_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_upper (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (up_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (col_cur[COL_W-1:0]),
        .rd_data (up_rd)
    );

    sobel_ram #(
        .DATA_W (LUM_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_middle (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (mid_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (col_cur[COL_W-1:0]),
        .rd_data (mid_rd)
    );

    // Stage 1: position info beside the luma divide and buffer read
    logic                 v1_reg, emit1_reg, done1_reg;
    logic [COL_W-1:0]     c1_reg;
    logic [OUT_COL_W-1:0] col1_reg;
    logic [OUT_ROW_W-1:0] row1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            emit1_reg <= emit_cur;
            done1_reg <= done_cur;
            c1_reg    <= col_cur[COL_W-1:0];
            col1_reg  <= col_m1[OUT_COL_W-1:0];
            row1_reg  <= row_m1[OUT_ROW_W-1:0];
        end
    end

    // Stage 2: luminance and buffer data captured
    logic                 v2_reg, emit2_reg, done2_reg;
    logic [COL_W-1:0]     c2_reg;
    logic [OUT_COL_W-1:0] col2_reg;
    logic [OUT_ROW_W-1:0] row2_reg;
    lum_t                 lum2_reg, up2_reg, mid2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            emit2_reg <= emit1_reg;
            done2_reg <= done1_reg;
            c2_reg    <= c1_reg;
            col2_reg  <= col1_reg;
            row2_reg  <= row1_reg;
            lum2_reg  <= lum1;
            up2_reg   <= up_rd;
            mid2_reg  <= mid_rd;
        end
    end

    // Records of the last two buffer writes, for narrow frames where a read
    // overlaps a write still in flight
    logic             w1_valid_reg, w2_valid_reg;
    logic [COL_W-1:0] w1_addr_reg, w2_addr_reg;
    lum_t             w1_up_reg, w1_mid_reg, w2_up_reg, w2_mid_reg;
    lum_t             up_eff, mid_eff;

    always_comb begin
        if (w1_valid_reg && (w1_addr_reg == c2_reg)) begin
            up_eff  = w1_up_reg;
            mid_eff = w1_mid_reg;
        end else if (w2_valid_reg && (w2_addr_reg == c2_reg)) begin
            up_eff  = w2_up_reg;
            mid_eff = w2_mid_reg;
        end else begin
            up_eff  = up2_reg;
            mid_eff = mid2_reg;
        end
    end

    assign buf_wr_en   = adv && v2_reg;
    assign buf_wr_addr = c2_reg;
    assign up_wr_data  = mid_eff;
    assign mid_wr_data = lum2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w1_valid_reg <= 1'b0;
            w2_valid_reg <= 1'b0;
        end else if (adv) begin
            w1_valid_reg <= v2_reg;
            w2_valid_reg <= w1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w1_addr_reg <= c2_reg;
            w1_up_reg   <= mid_eff;
            w1_mid_reg  <= lum2_reg;
            w2_addr_reg <= w1_addr_reg;
            w2_up_reg   <= w1_up_reg;
            w2_mid_reg  <= w1_mid_reg;
        end
    end

    // 3x2 window of the two columns to the left
    // index = column slot * 3 + row slot (upper, middle, current)
    lum_t win_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (adv && v2_reg) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up_eff;
            win_reg[4] <= mid_eff;
            win_reg[5] <= lum2_reg;
        end
    end

    // Sobel magnitude, clamp and threshold
    logic [SUM_W-1:0]   px, nx, py, ny, gx, gy;
    logic [SUM_W:0]     mag_sum;
    logic [7:0]         mag;
    logic [PIXEL_W-1:0] edge_pixel;

    always_comb begin
        px = SUM_W'(up_eff)     + {1'b0, mid_eff, 1'b0}    + SUM_W'(lum2_reg);
        nx = SUM_W'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + SUM_W'(win_reg[2]);
        py = SUM_W'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + SUM_W'(lum2_reg);
        ny = SUM_W'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + SUM_W'(up_eff);
        gx = (px > nx) ? (px - nx) : (nx - px);
        gy = (py > ny) ? (py - ny) : (ny - py);
        mag_sum = (SUM_W + 1)'(gx) + (SUM_W + 1)'(gy);
        mag = (mag_sum > MAG_MAX) ? 8'hFF : mag_sum[7:0];
        if (mag > edge_threshold_reg) begin
            edge_pixel = {ALPHA_OPAQUE, mag, mag, mag};
        end else begin
            edge_pixel = '0;
        end
    end

    // Output register
    logic                 out_valid_reg;
    logic [PIXEL_W-1:0]   out_pixel_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic                 out_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= v2_reg && emit2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_pixel_reg <= edge_pixel;
            out_col_reg   <= col2_reg;
            out_row_reg   <= row2_reg;
            out_done_reg  <= done2_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_row_reg, out_col_reg, out_pixel_reg};
    assign m_axis_tlast  = out_done_reg;

endmodule : sobel_edge_threshold_core

`default_nettype wire
